[hdl/ed_pkg.sv]
package ed_pkg;

  localparam int unsigned FuncW      = 2;
  localparam int unsigned CharW      = 8;
  localparam int unsigned DistW      = 7;
  localparam int unsigned MaxLenDflt = 64;

  // Request function codes
  localparam logic [FuncW-1:0] FuncAppend = 2'd0;
  localparam logic [FuncW-1:0] FuncStream = 2'd1;
  localparam logic [FuncW-1:0] FuncFinish = 2'd2;

  // What a token carries along the row of cells
  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindLoad   = 2'd1,
    KindStep   = 2'd2,
    KindFinish = 2'd3
  } ed_kind_e;

  typedef struct packed {
    ed_kind_e         kind;
    logic [CharW-1:0] chr;
    logic             fold;
    logic             ovf;
  } ed_ctl_t;

  // Fold ASCII uppercase to lowercase when enabled
  function automatic logic [CharW-1:0] ed_fold(input logic [CharW-1:0] b, input logic en);
    logic [CharW-1:0] r;
    r = b;
    if (en && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

[hdl/ed_req_if.sv]
interface ed_req_if import ed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [CharW-1:0] character;

  modport source (output valid, output func, output character, input ready);
  modport sink   (input valid, input func, input character, output ready);
endinterface

[hdl/ed_rsp_if.sv]
interface ed_rsp_if import ed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance;
  logic             overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

[hdl/ed_entry.sv]
module ed_entry import ed_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDflt,
  localparam int unsigned CW    = $clog2(MaxLen + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [FuncW-1:0] func_i,
  input  logic [CharW-1:0] character_i,
  input  logic             case_fold_i,
  output ed_ctl_t          ctl_o,
  output logic [CW-1:0]    cost_new_o,
  output logic [CW-1:0]    cost_old_o
);

  logic [CW-1:0] first_len_q, first_len_d;
  logic [CW-1:0] second_len_q, second_len_d;
  logic          ovf_q, ovf_d;

  always_comb begin
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    ovf_d        = ovf_q;
    ctl_o.kind   = KindNone;
    ctl_o.chr    = character_i;
    ctl_o.fold   = case_fold_i;
    ctl_o.ovf    = ovf_q;
    cost_new_o   = second_len_q;
    cost_old_o   = second_len_q;
    if (accept_i) begin
      unique case (func_i)
        FuncAppend: begin
          // drop appends once the column has moved past the first row
          if (second_len_q == '0) begin
            if (first_len_q < CW'(MaxLen)) begin
              ctl_o.kind  = KindLoad;
              first_len_d = first_len_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        FuncStream: begin
          if (second_len_q < CW'(MaxLen)) begin
            ctl_o.kind   = KindStep;
            ctl_o.chr    = ed_fold(character_i, case_fold_i);
            second_len_d = second_len_q + CW'(1);
            cost_new_o   = second_len_d;
          end else begin
            ovf_d = 1'b1;
          end
        end
        FuncFinish: begin
          ctl_o.kind   = KindFinish;
          first_len_d  = '0;
          second_len_d = '0;
          ovf_d        = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= '0;
      second_len_q <= '0;
      ovf_q        <= 1'b0;
    end else begin
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

[hdl/ed_cell.sv]
module ed_cell import ed_pkg::*; #(
  parameter int unsigned CW  = 7,
  parameter int unsigned Idx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  ed_ctl_t       ctl_i,
  input  logic [CW-1:0] cost_new_i,
  input  logic [CW-1:0] cost_old_i,
  output ed_ctl_t       ctl_o,
  output logic [CW-1:0] cost_new_o,
  output logic [CW-1:0] cost_old_o
);

  localparam logic [CW-1:0] CostInit = CW'(Idx + 1);

  logic [CharW-1:0] byte_q, byte_d;
  logic             used_q, used_d;
  logic [CW-1:0]    cost_q, cost_d;
  ed_ctl_t          ctl_d;
  ed_kind_e         kind_q;
  logic [CharW-1:0] chr_q;
  logic             fold_q;
  logic             ovf_q;
  logic [CW-1:0]    cnew_q, cnew_d;
  logic [CW-1:0]    cold_q, cold_d;

  logic [CW:0] up1, del1, sub1, best;
  logic        match;

  always_comb begin
    match = (ed_fold(byte_q, ctl_i.fold) == ctl_i.chr);
    up1   = {1'b0, cost_q} + (CW+1)'(1);
    del1  = {1'b0, cost_new_i} + (CW+1)'(1);
    sub1  = {1'b0, cost_old_i} + (match ? (CW+1)'(0) : (CW+1)'(1));
    best  = up1;
    if (del1 < best) best = del1;
    if (sub1 < best) best = sub1;
  end

  always_comb begin
    byte_d = byte_q;
    used_d = used_q;
    cost_d = cost_q;
    ctl_d  = ctl_i;
    cnew_d = cost_new_i;
    cold_d = cost_old_i;
    case (ctl_i.kind)
      KindLoad: begin
        // the first free cell takes the byte
        if (!used_q) begin
          byte_d     = ctl_i.chr;
          used_d     = 1'b1;
          ctl_d.kind = KindNone;
        end
      end
      KindStep: begin
        if (used_q) begin
          cost_d = best[CW-1:0];
          cnew_d = best[CW-1:0];
          cold_d = cost_q;
        end
      end
      KindFinish: begin
        // the last used cell leaves its cost as the result
        if (used_q) begin
          cnew_d = cost_q;
        end
        used_d = 1'b0;
        cost_d = CostInit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      cost_q <= CostInit;
      kind_q <= KindNone;
    end else if (en_i) begin
      used_q <= used_d;
      cost_q <= cost_d;
      kind_q <= ctl_d.kind;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= byte_d;
      chr_q  <= ctl_d.chr;
      fold_q <= ctl_d.fold;
      ovf_q  <= ctl_d.ovf;
      cnew_q <= cnew_d;
      cold_q <= cold_d;
    end
  end

  assign ctl_o      = '{kind: kind_q, chr: chr_q, fold: fold_q, ovf: ovf_q};
  assign cost_new_o = cnew_q;
  assign cost_old_o = cold_q;

endmodule

[hdl/edit_distance_engine.sv]
// Levenshtein edit distance engine.
// Requests arrive on req_i (valid/ready, func and character). func append
// stores a byte of the first string, func stream runs one byte of the second
// string against it, func finish returns the distance on rsp_o and clears
// the strings. Bytes past MAX_LEN in either string are dropped and flagged.
// case_fold_we_i writes case_fold_i, which folds A-Z to a-z for comparisons.
// A row of MAX_LEN cells holds one stored byte and one column cost each;
// every request enters the row as a token and, unless the row holds, moves
// one cell per cycle, so a second-string byte sweeps the column as a
// skewed wavefront. Throughput: one request per cycle while req_i.ready is
// high, whatever its function. A finish request enters cell 0 at the edge
// that accepts it, passes each cell register of the row in turn, and the
// output register takes its result from the last cell.
// Reset clears the strings, lengths, overflow flag and case_fold.
// While a finished result waits on rsp_o and the next finish token reaches
// the end of the row, the whole row holds and req_i.ready drops; otherwise
// requests keep flowing while the result waits.
module edit_distance_engine import ed_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDflt
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  ed_req_if.sink   req_i,
  ed_rsp_if.source rsp_o,
  input  logic    case_fold_we_i,
  input  logic    case_fold_i
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  logic          case_fold_q;
  logic          en;
  logic          accept;
  logic          take;
  ed_ctl_t       ctl      [MAX_LEN+1];
  logic [CW-1:0] cost_new [MAX_LEN+1];
  logic [CW-1:0] cost_old [MAX_LEN+1];

  logic             out_valid_q, out_valid_d;
  logic [DistW-1:0] distance_q;
  logic             overflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_fold_q <= 1'b0;
    end else if (case_fold_we_i) begin
      case_fold_q <= case_fold_i;
    end
  end

  assign take        = (ctl[MAX_LEN].kind == KindFinish);
  assign en          = !(take && out_valid_q && !rsp_o.ready);
  assign req_i.ready = en;
  assign accept      = req_i.valid && en;

  ed_entry #(.MaxLen(MAX_LEN)) u_entry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (req_i.func),
    .character_i (req_i.character),
    .case_fold_i (case_fold_q),
    .ctl_o       (ctl[0]),
    .cost_new_o  (cost_new[0]),
    .cost_old_o  (cost_old[0])
  );

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    ed_cell #(.CW(CW), .Idx(i)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .ctl_i      (ctl[i]),
      .cost_new_i (cost_new[i]),
      .cost_old_i (cost_old[i]),
      .ctl_o      (ctl[i+1]),
      .cost_new_o (cost_new[i+1]),
      .cost_old_o (cost_old[i+1])
    );
  end

  assign out_valid_d = (out_valid_q && !rsp_o.ready) || (take && en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && en) begin
      distance_q <= DistW'(cost_new[MAX_LEN]);
      overflow_q <= ctl[MAX_LEN].ovf;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.distance = distance_q;
  assign rsp_o.overflow = overflow_q;

endmodule
